>>> src/rgb_color_cube_composite_core_assert.svh
// Assertion macros for the color cube composite block.
// Clocked on clk, held off while rst_n is low.
`ifndef RGB_COLOR_CUBE_COMPOSITE_CORE_ASSERT_SVH
`define RGB_COLOR_CUBE_COMPOSITE_CORE_ASSERT_SVH

// expression holds at every clock edge
`define RGBCC_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rgbcc: check failed");

// antecedent at one edge implies consequent at the next edge
`define RGBCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbcc: check failed");

`endif

>>> src/rgbcc_pkg.sv
`default_nettype none

package rgbcc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int CELL_BITS   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int NUM_CH      = 3;
    localparam int LEVEL_W     = 8;
    localparam int BYTE_W      = 8;
    localparam int CAT_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int MQ_DEPTH    = 4;
    localparam int MQ_PTR_W    = $clog2(MQ_DEPTH);
    localparam int OQ_DEPTH    = 2;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);

    localparam logic [NUM_CH*LEVEL_W-1:0] LEVELS_RESET  = 24'h060606;
    localparam logic [NUM_CH-1:0]         ENABLES_RESET = 3'b111;
    localparam int                        CH_MAX_RESET  = 255;

    typedef logic [CELL_BITS-1:0] cell_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [LEVEL_W-1:0]   level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_MIN    = 3'd0,
        CFG_RED_MAX    = 3'd1,
        CFG_GREEN_MIN  = 3'd2,
        CFG_GREEN_MAX  = 3'd3,
        CFG_BLUE_MIN   = 3'd4,
        CFG_BLUE_MAX   = 3'd5,
        CFG_LEVELS     = 3'd6,
        CFG_ENABLES    = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_LOAD  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } sel_t;

    typedef struct packed {
        cell_t  [NUM_CH-1:0] ch_min;
        cell_t  [NUM_CH-1:0] ch_max;
        level_t [NUM_CH-1:0] levels;
        logic   [NUM_CH-1:0] enables;
    } cfg_t;

    // one classified item: a table write or a pixel with per-channel lookups
    typedef struct packed {
        logic                is_load;
        byte_t               ld_byte;
        logic  [NUM_CH-1:0]  hit;
        addr_t [NUM_CH-1:0]  addr;
    } mq_entry_t;

    typedef struct packed {
        logic      valid;
        mq_entry_t entry;
    } mq_head_t;

endpackage

`default_nettype wire

>>> src/rgb_color_cube_composite_core.sv
// Color cube composite: maps a pixel's red, green and blue cell values to one
// category, 1 plus the weighted per-channel quantized table bytes.
// Input channel: an item is taken when push is high and full is low. A load
// item (command high) writes one byte into the red, green or blue table (none
// for select 3) and gives no result; a pixel item gives exactly one category.
// Result channel: while empty is low the oldest category is on the port; it
// leaves when pop is high.
// A pixel passes through the item queue, table read, product, quantized level
// and weighted terms into the result queue. Throughput: one item per cycle
// unless the pipe holds, set by the table access that every item makes once.
// A four-item queue separates classification from the lookup pipeline, and
// a two-item queue holds results; when pop stays low the pipeline holds and
// full rises once the front queue fills.
// Configuration: write_enable, write_index, write_data; write only while idle.
// Reset clears the queues and loads default bounds, levels and enables; the
// tables are not cleared and must be loaded before pixels read them.
`default_nettype none

module rgb_color_cube_composite_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output      logic                                   full,
    input  wire logic                                   command,
    input  wire logic [1:0]                             table_select,
    input  wire logic [7:0]                             table_index,
    input  wire logic [7:0]                             table_byte,
    input  wire logic signed [rgbcc_pkg::CELL_BITS-1:0] red_value,
    input  wire logic signed [rgbcc_pkg::CELL_BITS-1:0] green_value,
    input  wire logic signed [rgbcc_pkg::CELL_BITS-1:0] blue_value,
    output      logic                                   empty,
    input  wire logic                                   pop,
    output      logic [rgbcc_pkg::CAT_W-1:0]            category,
    input  wire logic                                   write_enable,
    input  wire logic [rgbcc_pkg::CFG_IDX_W-1:0]        write_index,
    input  wire logic [rgbcc_pkg::CFG_DATA_W-1:0]       write_data
);

    import rgbcc_pkg::*;

    cfg_t     cfg_reg;
    mq_head_t head;
    logic     mq_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ch_min  <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                cfg_reg.ch_max[i] <= CELL_BITS'(CH_MAX_RESET);
            end
            cfg_reg.levels  <= LEVELS_RESET;
            cfg_reg.enables <= ENABLES_RESET;
        end
        else if (write_enable)
        begin
            unique case (cfg_idx_t'(write_index))
                CFG_RED_MIN:   cfg_reg.ch_min[0] <= write_data[CELL_BITS-1:0];
                CFG_RED_MAX:   cfg_reg.ch_max[0] <= write_data[CELL_BITS-1:0];
                CFG_GREEN_MIN: cfg_reg.ch_min[1] <= write_data[CELL_BITS-1:0];
                CFG_GREEN_MAX: cfg_reg.ch_max[1] <= write_data[CELL_BITS-1:0];
                CFG_BLUE_MIN:  cfg_reg.ch_min[2] <= write_data[CELL_BITS-1:0];
                CFG_BLUE_MAX:  cfg_reg.ch_max[2] <= write_data[CELL_BITS-1:0];
                CFG_LEVELS:    cfg_reg.levels    <= write_data[NUM_CH*LEVEL_W-1:0];
                CFG_ENABLES:   cfg_reg.enables   <= write_data[NUM_CH-1:0];
            endcase
        end
    end

    rgbcc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .table_select (table_select),
        .table_index  (table_index),
        .table_byte   (table_byte),
        .red_value    (red_value),
        .green_value  (green_value),
        .blue_value   (blue_value),
        .cfg          (cfg_reg),
        .head         (head),
        .mq_pop       (mq_pop)
    );

    rgbcc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .mq_pop   (mq_pop),
        .cfg      (cfg_reg),
        .empty    (empty),
        .pop      (pop),
        .category (category)
    );

endmodule

`default_nettype wire

>>> src/rgbcc_ram.sv
`default_nettype none

module rgbcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/rgbcc_front.sv
`default_nettype none

module rgbcc_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output      logic                              full,
    input  wire logic                              command,
    input  wire logic [1:0]                        table_select,
    input  wire logic [7:0]                        table_index,
    input  wire logic [7:0]                        table_byte,
    input  wire logic signed [rgbcc_pkg::CELL_BITS-1:0] red_value,
    input  wire logic signed [rgbcc_pkg::CELL_BITS-1:0] green_value,
    input  wire logic signed [rgbcc_pkg::CELL_BITS-1:0] blue_value,
    input  wire rgbcc_pkg::cfg_t                   cfg,
    output      rgbcc_pkg::mq_head_t               head,
    input  wire logic                              mq_pop
);

    import rgbcc_pkg::*;

    cell_t     vals [NUM_CH];
    cell_t     off_u;
    mq_entry_t entry_next;

    mq_entry_t             mq_reg [MQ_DEPTH];
    logic [MQ_PTR_W-1:0]   wr_ptr_reg;
    logic [MQ_PTR_W-1:0]   rd_ptr_reg;
    logic [MQ_PTR_W:0]     count_reg;
    logic [MQ_PTR_W:0]     count_next;
    logic                  do_push;
    logic                  do_pop;

    assign vals[0] = red_value;
    assign vals[1] = green_value;
    assign vals[2] = blue_value;

    always_comb
    begin
        entry_next         = '0;
        off_u              = '0;
        entry_next.ld_byte = table_byte;
        if (cmd_t'(command) == CMD_LOAD)
        begin
            entry_next.is_load = 1'b1;
            for (int i = 0; i < NUM_CH; i++)
            begin
                entry_next.addr[i] = ADDR_W'(table_index);
            end
            if (int'(table_index) < TABLE_DEPTH)
            begin
                unique case (table_select)
                    SEL_RED:   entry_next.hit = 3'b001;
                    SEL_GREEN: entry_next.hit = 3'b010;
                    SEL_BLUE:  entry_next.hit = 3'b100;
                    default:   entry_next.hit = 3'b000;
                endcase
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                off_u              = vals[i] - cfg.ch_min[i];
                entry_next.addr[i] = ADDR_W'(off_u);
                entry_next.hit[i]  = cfg.enables[i]
                                     && ($signed(vals[i]) >= $signed(cfg.ch_min[i]))
                                     && ($signed(vals[i]) <= $signed(cfg.ch_max[i]))
                                     && (int'(off_u) < TABLE_DEPTH);
            end
        end
    end

    // item queue toward the back end
    assign full       = (count_reg == (MQ_PTR_W+1)'(MQ_DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = mq_pop && head.valid;
    assign count_next = count_reg + (MQ_PTR_W+1)'(do_push) - (MQ_PTR_W+1)'(do_pop);

    assign head.valid = (count_reg != '0);
    assign head.entry = mq_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mq_reg[wr_ptr_reg] <= entry_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rgbcc_back.sv
`default_nettype none

module rgbcc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rgbcc_pkg::mq_head_t           head,
    output      logic                          mq_pop,
    input  wire rgbcc_pkg::cfg_t               cfg,
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic [rgbcc_pkg::CAT_W-1:0]   category
);

    import rgbcc_pkg::*;

    logic                 adv;
    byte_t                rdata [NUM_CH];

    logic                 s1_valid_reg;
    logic [NUM_CH-1:0]    s1_hit_reg;
    logic                 s2_valid_reg;
    logic [NUM_CH-1:0]    s2_hit_reg;
    logic [15:0]          x_reg [NUM_CH];
    logic                 s3_valid_reg;
    level_t               z_reg [NUM_CH];
    level_t               z_next [NUM_CH];
    logic [16:0]          qsum [NUM_CH];
    level_t               q8 [NUM_CH];
    logic                 s4_valid_reg;
    logic [CAT_W-1:0]     t_red_reg;
    logic [CAT_W-1:0]     t_green_reg;
    logic [CAT_W-1:0]     t_blue_reg;
    logic [15:0]          gb_reg;
    logic [CAT_W-1:0]     cat_next;

    logic [CAT_W-1:0]     oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  owr_ptr_reg;
    logic [OQ_PTR_W-1:0]  ord_ptr_reg;
    logic [OQ_PTR_W:0]    ocount_reg;
    logic                 oq_full;
    logic                 oq_push;
    logic                 oq_pop;

    // whole pipe holds while the last stage cannot drain
    assign adv    = !(s4_valid_reg && oq_full);
    assign mq_pop = head.valid && adv;

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_tab
        rgbcc_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (TABLE_DEPTH)
        ) u_tab (
            .clk   (clk),
            .we    (mq_pop && head.entry.is_load && head.entry.hit[i]),
            .waddr (head.entry.addr[i]),
            .wdata (head.entry.ld_byte),
            .re    (adv),
            .raddr (head.entry.addr[i]),
            .rdata (rdata[i])
        );
    end

    // quantize: floor(x / 255) for x up to 255 * 255, then clamp to level - 1; zero on a miss or zero levels
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            qsum[i] = 17'(x_reg[i]) + 17'(x_reg[i] >> 8) + 17'd1;
            q8[i]   = qsum[i][15:8];
            if (!s2_hit_reg[i] || (cfg.levels[i] == '0))
            begin
                z_next[i] = '0;
            end
            else if (q8[i] >= cfg.levels[i])
            begin
                z_next[i] = cfg.levels[i] - 1'b1;
            end
            else
            begin
                z_next[i] = q8[i];
            end
        end
    end

    assign cat_next = CAT_W'(1) + t_red_reg + t_green_reg + t_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= head.valid && !head.entry.is_load;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        gb_reg <= 16'(cfg.levels[1]) * 16'(cfg.levels[2]);
        if (adv)
        begin
            s1_hit_reg <= head.entry.hit;
            s2_hit_reg <= s1_hit_reg;
            for (int i = 0; i < NUM_CH; i++)
            begin
                x_reg[i] <= 16'(rdata[i]) * 16'(cfg.levels[i]);
                z_reg[i] <= z_next[i];
            end
            t_red_reg   <= CAT_W'(z_reg[0]) * CAT_W'(gb_reg);
            t_green_reg <= CAT_W'(z_reg[1]) * CAT_W'(cfg.levels[2]);
            t_blue_reg  <= CAT_W'(z_reg[2]);
        end
    end

    // result queue
    assign oq_full  = (ocount_reg == (OQ_PTR_W+1)'(OQ_DEPTH));
    assign oq_push  = s4_valid_reg && !oq_full;
    assign empty    = (ocount_reg == '0);
    assign oq_pop   = pop && !empty;
    assign category = oq_reg[ord_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                owr_ptr_reg <= owr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                ord_ptr_reg <= ord_ptr_reg + 1'b1;
            end
            ocount_reg <= ocount_reg + (OQ_PTR_W+1)'(oq_push) - (OQ_PTR_W+1)'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[owr_ptr_reg] <= cat_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rgbcc_checker.sv
`default_nettype none

`include "rgb_color_cube_composite_core_assert.svh"

module rgbcc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [23:0] category
);

    // a waiting result stays put until taken
    `RGBCC_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(category))

    // the category always counts from one
    `RGBCC_ASSERT_HOLDS(a_category_nonzero, empty || (category != 24'd0))

    // largest cube: every level at 255
    `RGBCC_ASSERT_HOLDS(a_category_bound, empty || (category <= 24'd16581375))

endmodule

bind rgb_color_cube_composite_core rgbcc_checker u_rgbcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .category (category)
);

`default_nettype wire

>>> dv/rgb_color_cube_composite_core_tb.sv
`timescale 1ns / 1ps

module rgb_color_cube_composite_core_tb;

    import rgbcc_pkg::*;

    localparam logic [1:0] SEL_NONE      = 2'd3;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         QUIET_LIMIT   = 1000;
    localparam int         PHASE_ITEMS   = 50;
    localparam int         NUM_PHASES    = 6;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  push         = 1'b0;
    logic                  full;
    logic                  command      = 1'b0;
    logic [1:0]            table_select = 2'd0;
    logic [7:0]            table_index  = 8'd0;
    logic [7:0]            table_byte   = 8'd0;
    logic [CELL_BITS-1:0]  red_value    = '0;
    logic [CELL_BITS-1:0]  green_value  = '0;
    logic [CELL_BITS-1:0]  blue_value   = '0;
    logic                  empty;
    logic                  pop          = 1'b0;
    logic [CAT_W-1:0]      category;
    logic                  write_enable = 1'b0;
    logic [CFG_IDX_W-1:0]  write_index  = '0;
    logic [CFG_DATA_W-1:0] write_data   = '0;

    // shadow of the block's configuration and tables
    logic signed [CELL_BITS-1:0] lim_lo [0:2] = '{16'sd0, 16'sd0, 16'sd0};
    logic signed [CELL_BITS-1:0] lim_hi [0:2] =
        '{CELL_BITS'(CH_MAX_RESET), CELL_BITS'(CH_MAX_RESET), CELL_BITS'(CH_MAX_RESET)};
    logic [23:0]                 lvl_word = LEVELS_RESET;
    logic [2:0]                  en_bits  = ENABLES_RESET;
    byte_t                       tbl_bytes [0:2][0:TABLE_DEPTH-1];
    bit                          tbl_set   [0:2][0:TABLE_DEPTH-1];

    logic [CAT_W-1:0] category_q [$];
    logic [CAT_W-1:0] exp_cat;
    int               err_count    = 0;
    int               quiet_cycles = 0;
    int               stall_left   = 0;
    bit               idle_on      = 1'b1;

    rgb_color_cube_composite_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .table_select (table_select),
        .table_index  (table_index),
        .table_byte   (table_byte),
        .red_value    (red_value),
        .green_value  (green_value),
        .blue_value   (blue_value),
        .empty        (empty),
        .pop          (pop),
        .category     (category),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned channel_term(int ch, logic signed [CELL_BITS-1:0] v,
                                                 int unsigned lvl, int unsigned weight);
        int          vi;
        int          lo;
        int          hi;
        int          off;
        int unsigned q;
        vi = int'(v);
        lo = int'(lim_lo[ch]);
        hi = int'(lim_hi[ch]);
        if (vi < lo || vi > hi)
            return 0;
        off = vi - lo;
        if (off >= TABLE_DEPTH)
            return 0;
        q = 32'(tbl_bytes[ch][off]) * lvl / 255;
        if (lvl == 0)
            q = 0;
        else if (q >= lvl)
            q = lvl - 1;
        return q * weight;
    endfunction

    function automatic logic [CAT_W-1:0] category_of(logic signed [CELL_BITS-1:0] r,
                                                     logic signed [CELL_BITS-1:0] g,
                                                     logic signed [CELL_BITS-1:0] b);
        int unsigned rl;
        int unsigned gl;
        int unsigned bl;
        int unsigned sum;
        rl = 32'(lvl_word[7:0]);
        gl = 32'(lvl_word[15:8]);
        bl = 32'(lvl_word[23:16]);
        sum = 1;
        if (en_bits[0])
            sum += channel_term(0, r, rl, gl * bl);
        if (en_bits[1])
            sum += channel_term(1, g, gl, bl);
        if (en_bits[2])
            sum += channel_term(2, b, bl, 1);
        return sum[CAT_W-1:0];
    endfunction

    // true when the value would read a table entry not loaded yet
    function automatic bit reads_unwritten(int ch, logic signed [CELL_BITS-1:0] v);
        int vi;
        int lo;
        int hi;
        int off;
        vi = int'(v);
        lo = int'(lim_lo[ch]);
        hi = int'(lim_hi[ch]);
        if (vi < lo || vi > hi)
            return 1'b0;
        off = vi - lo;
        if (off >= TABLE_DEPTH)
            return 1'b0;
        return !tbl_set[ch][off];
    endfunction

    // value biased toward the painted window of a channel
    function automatic logic [CELL_BITS-1:0] pick_raw(int ch);
        int lo;
        int hi;
        int m;
        lo = int'(lim_lo[ch]);
        hi = int'(lim_hi[ch]);
        m = $urandom_range(0, 9);
        if (m <= 5)
            return CELL_BITS'(lo + int'($urandom_range(0, 255)));
        if (m == 6)
        begin
            case ($urandom_range(0, 3))
                0: return CELL_BITS'(lo - 1);
                1: return CELL_BITS'(lo);
                2: return CELL_BITS'(hi);
                default: return CELL_BITS'(hi + 1);
            endcase
        end
        if (m <= 8)
            return CELL_BITS'(lo + int'($urandom_range(0, 400)));
        return CELL_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CELL_BITS-1:0] pick_value(int ch);
        logic [CELL_BITS-1:0] v;
        for (int t = 0; t < 8; t++)
        begin
            v = pick_raw(ch);
            if (!reads_unwritten(ch, v))
                return v;
        end
        // one past the table or wrapped below the minimum: never read
        return CELL_BITS'(int'(lim_lo[ch]) + TABLE_DEPTH);
    endfunction

    // shadow update and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (category_q.size() == 0)
                begin
                    $display("%0t: unexpected category, expected none actual %0d",
                             $time, category);
                    err_count++;
                end
                else
                begin
                    exp_cat = category_q.pop_front();
                    if (category !== exp_cat)
                    begin
                        $display("%0t: category mismatch, expected %0d actual %0d",
                                 $time, exp_cat, category);
                        err_count++;
                    end
                end
            end
            if (push && !full)
            begin
                if (command == CMD_LOAD)
                begin
                    if (table_select != SEL_NONE)
                    begin
                        tbl_bytes[table_select][table_index] = table_byte;
                        tbl_set[table_select][table_index]   = 1'b1;
                    end
                end
                else
                    category_q.push_back(category_of(red_value, green_value, blue_value));
            end
            if (write_enable)
            begin
                case (cfg_idx_t'(write_index))
                    CFG_RED_MIN:   lim_lo[0] = write_data[CELL_BITS-1:0];
                    CFG_RED_MAX:   lim_hi[0] = write_data[CELL_BITS-1:0];
                    CFG_GREEN_MIN: lim_lo[1] = write_data[CELL_BITS-1:0];
                    CFG_GREEN_MAX: lim_hi[1] = write_data[CELL_BITS-1:0];
                    CFG_BLUE_MIN:  lim_lo[2] = write_data[CELL_BITS-1:0];
                    CFG_BLUE_MAX:  lim_hi[2] = write_data[CELL_BITS-1:0];
                    CFG_LEVELS:    lvl_word  = write_data[23:0];
                    CFG_ENABLES:   en_bits   = write_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    // result side stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || write_enable)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
                $display("rgb_color_cube_composite_core_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(cmd_t cmd, logic [1:0] tsel, logic [7:0] tidx, logic [7:0] tbyte,
                             logic [CELL_BITS-1:0] r, logic [CELL_BITS-1:0] g,
                             logic [CELL_BITS-1:0] b);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        push         <= 1'b1;
        command      <= cmd;
        table_select <= tsel;
        table_index  <= tidx;
        table_byte   <= tbyte;
        red_value    <= r;
        green_value  <= g;
        blue_value   <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_pixel(logic [CELL_BITS-1:0] r, logic [CELL_BITS-1:0] g,
                              logic [CELL_BITS-1:0] b);
        send_item(CMD_PIXEL, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), r, g, b);
    endtask

    task automatic send_load(logic [1:0] tsel, logic [7:0] tidx, logic [7:0] tbyte);
        send_item(CMD_LOAD, tsel, tidx, tbyte, CELL_BITS'($urandom_range(0, 65535)),
                  CELL_BITS'($urandom_range(0, 65535)), CELL_BITS'($urandom_range(0, 65535)));
    endtask

    // wait for all categories, then let trailing loads drain
    task automatic settle();
        push <= 1'b0;
        while (category_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(logic [15:0] rlo, logic [15:0] rhi, logic [15:0] glo,
                                logic [15:0] ghi, logic [15:0] blo, logic [15:0] bhi,
                                logic [23:0] lv, logic [2:0] en);
        settle();
        // upper bits of narrow registers carry junk
        write_one(CFG_RED_MIN,   {8'($urandom_range(0, 255)), rlo});
        write_one(CFG_RED_MAX,   {8'($urandom_range(0, 255)), rhi});
        write_one(CFG_GREEN_MIN, {8'($urandom_range(0, 255)), glo});
        write_one(CFG_GREEN_MAX, {8'($urandom_range(0, 255)), ghi});
        write_one(CFG_BLUE_MIN,  {8'($urandom_range(0, 255)), blo});
        write_one(CFG_BLUE_MAX,  {8'($urandom_range(0, 255)), bhi});
        write_one(CFG_LEVELS,    lv);
        write_one(CFG_ENABLES,   {21'($urandom_range(0, 2097151)), en});
        write_enable <= 1'b0;
    endtask

    // first and last sixteen entries of each table, every fourth one in between, and a load to no table
    task automatic test_table_fill();
        logic [7:0] tbyte;
        for (int s = 0; s < 3; s++)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (i >= 16 && i < TABLE_DEPTH - 16 && (i % 4) != 0)
                    continue;
                if (i == 0)
                    tbyte = 8'h00;
                else if (i == TABLE_DEPTH - 1)
                    tbyte = 8'hFF;
                else
                    tbyte = 8'($urandom_range(0, 255));
                send_load(sel_t'(s), 8'(i), tbyte);
            end
            send_load(SEL_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_default_pixels();
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd255, 16'd255, 16'd255);
        send_pixel(16'hFFFF, 16'd256, 16'd128);
        send_pixel(16'h8000, 16'h7FFF, 16'd1);
        send_pixel(16'd100, 16'd200, 16'd52);
    endtask

    task automatic test_bound_extremes();
        apply_config(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                     24'hFFFFFF, 3'b111);
        send_pixel(16'h80FF, 16'h80FF, 16'h80FF);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'h8100, 16'h80FF, 16'h8000);
        send_pixel(16'h7FFF, 16'h7FFF, 16'h80FF);
        send_pixel(16'h80FE, 16'h8080, 16'h80FF);
    endtask

    task automatic test_levels_and_enables();
        logic [2:0] en;
        apply_config(16'd0, 16'd255, 16'd0, 16'd255, 16'd0, 16'd255, 24'h000000, 3'b111);
        send_pixel(16'd255, 16'd255, 16'd255);
        send_pixel(16'd0, 16'd128, 16'd255);
        apply_config(16'd0, 16'd255, 16'd0, 16'd255, 16'd0, 16'd255, 24'h010101, 3'b111);
        send_pixel(16'd255, 16'd255, 16'd255);
        // min above max: nothing painted
        apply_config(16'd10, 16'd5, 16'd10, 16'd5, 16'd10, 16'd5, 24'hFFFFFF, 3'b111);
        send_pixel(16'd7, 16'd7, 16'd7);
        send_pixel(16'd10, 16'd5, 16'd10);
        for (int i = 0; i < 4; i++)
        begin
            en = (i == 0) ? 3'b000 : 3'(1 << (i - 1));
            apply_config(16'd0, 16'd255, 16'd0, 16'd255, 16'd0, 16'd255, 24'h0A0305, en);
            send_pixel(16'd255, 16'd255, 16'd255);
            send_pixel(16'd100, 16'd200, 16'd36);
        end
    endtask

    task automatic test_random();
        int                    lo_v [3];
        int                    hi_v [3];
        logic [7:0]            lv   [3];
        logic signed [15:0]    rnd16;
        logic [2:0]            en;
        int                    n;
        int                    k;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                rnd16 = 16'($urandom_range(0, 65535));
                case ($urandom_range(0, 7))
                    0, 1, 2, 3:
                    begin
                        lo_v[ch] = int'($urandom_range(0, 600)) - 300;
                        hi_v[ch] = lo_v[ch] + int'($urandom_range(0, 300));
                    end
                    4:
                    begin
                        lo_v[ch] = int'(rnd16);
                        hi_v[ch] = lo_v[ch] + int'($urandom_range(0, 400));
                        if (hi_v[ch] > 32767)
                            hi_v[ch] = 32767;
                    end
                    5:
                    begin
                        lo_v[ch] = $urandom_range(0, 200);
                        hi_v[ch] = lo_v[ch] - int'($urandom_range(1, 50));
                    end
                    6:
                    begin
                        lo_v[ch] = -32768;
                        hi_v[ch] = 32767;
                    end
                    default:
                    begin
                        lo_v[ch] = int'(rnd16);
                        rnd16 = 16'($urandom_range(0, 65535));
                        hi_v[ch] = int'(rnd16);
                    end
                endcase
                case ($urandom_range(0, 9))
                    0: lv[ch] = 8'd0;
                    1: lv[ch] = 8'd1;
                    2: lv[ch] = 8'd255;
                    3, 4, 5, 6: lv[ch] = 8'($urandom_range(2, 8));
                    default: lv[ch] = 8'($urandom_range(0, 255));
                endcase
            end
            en = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
            apply_config(16'(lo_v[0]), 16'(hi_v[0]), 16'(lo_v[1]), 16'(hi_v[1]),
                         16'(lo_v[2]), 16'(hi_v[2]), {lv[2], lv[1], lv[0]}, en);
            idle_on = (p < NUM_PHASES - 1);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                k = $urandom_range(0, 99);
                if (k < 80)
                begin
                    send_pixel(pick_value(0), pick_value(1), pick_value(2));
                    n++;
                end
                else if (k < 95)
                begin
                    send_load(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                    n++;
                end
                else
                    send_load(SEL_NONE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_default_pixels();
        test_bound_extremes();
        test_levels_and_enables();
        test_random();
        settle();
        if (err_count == 0)
            $display("rgb_color_cube_composite_core_tb: PASS");
        else
            $display("rgb_color_cube_composite_core_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/rgbcc_pkg.sv
src/rgbcc_ram.sv
src/rgbcc_front.sv
src/rgbcc_back.sv
src/rgb_color_cube_composite_core.sv
src/rgbcc_checker.sv
dv/rgb_color_cube_composite_core_tb.sv
